// File: src/csem_pkg.sv
// Shared types, sizes and codes for the counting semaphore wait queue unit.
package csem_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;

  localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam int COUNT_W   = 16;
  localparam int THREAD_W  = 8;
  localparam int STATUS_W  = 3;
  localparam int WAITERS_W = 5;

  localparam logic [COUNT_W-1:0]   COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [PTR_BITS-1:0]  PTR_LAST   = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [FILL_BITS-1:0] FILL_FULL  = FILL_BITS'(QUEUE_DEPTH);

  localparam logic KIND_WAIT   = 1'b0;
  localparam logic KIND_SIGNAL = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WOKE      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd5;

  typedef struct packed {
    logic capture;
    logic execute;
  } csem_cmd_t;

endpackage

// File: src/csem_ctrl.sv
// Controller state machine: request intake, execute step and output valid.
module csem_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output csem_pkg::csem_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  assign in_stall    = (state != S_IDLE);
  assign out_free    = !out_valid || !out_stall;
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.execute = (state == S_EXEC) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    priority if (cmd.execute) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: src/csem_dp.sv
// Datapath: semaphore count, waiter ring memory with pointers, result register.
module csem_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  csem_pkg::csem_cmd_t               cmd,
  input  logic                              cfg_we,
  input  logic [csem_pkg::COUNT_W-1:0]      cfg_wdata,
  input  logic                              kind,
  input  logic [csem_pkg::THREAD_W-1:0]     thread_id,
  output logic [csem_pkg::STATUS_W-1:0]     status,
  output logic [csem_pkg::THREAD_W-1:0]     woken_thread,
  output logic [csem_pkg::COUNT_W-1:0]      count_after,
  output logic [csem_pkg::WAITERS_W-1:0]    waiters_after
);

  logic [csem_pkg::ID_BITS-1:0] ring [csem_pkg::QUEUE_DEPTH];
  logic [csem_pkg::ID_BITS-1:0] rd_data;

  logic [csem_pkg::COUNT_W-1:0]   count;
  logic [csem_pkg::PTR_BITS-1:0]  head;
  logic [csem_pkg::PTR_BITS-1:0]  tail;
  logic [csem_pkg::FILL_BITS-1:0] fill;

  logic                           req_kind;
  logic [csem_pkg::ID_BITS-1:0]   req_tid;

  logic [csem_pkg::COUNT_W-1:0]   count_next;
  logic [csem_pkg::PTR_BITS-1:0]  head_next;
  logic [csem_pkg::PTR_BITS-1:0]  tail_next;
  logic [csem_pkg::FILL_BITS-1:0] fill_next;
  logic [csem_pkg::STATUS_W-1:0]  status_next;
  logic [csem_pkg::ID_BITS-1:0]   woken_next;
  logic                           push;

  always_comb begin
    count_next  = count;
    head_next   = head;
    tail_next   = tail;
    fill_next   = fill;
    woken_next  = '0;
    push        = 1'b0;
    status_next = csem_pkg::ST_GRANTED;
    if (req_kind == csem_pkg::KIND_WAIT) begin
      priority if (count != '0) begin
        count_next  = count - 1'b1;
        status_next = csem_pkg::ST_GRANTED;
      end else if (fill != csem_pkg::FILL_FULL) begin
        push        = 1'b1;
        tail_next   = (tail == csem_pkg::PTR_LAST) ? '0 : tail + 1'b1;
        fill_next   = fill + 1'b1;
        status_next = csem_pkg::ST_QUEUED;
      end else begin
        status_next = csem_pkg::ST_FULL;
      end
    end else begin
      if (fill != '0) begin
        woken_next = rd_data;
        head_next  = (head == csem_pkg::PTR_LAST) ? '0 : head + 1'b1;
        fill_next  = fill - 1'b1;
      end
      if (count != csem_pkg::COUNT_MAX) begin
        count_next = count + 1'b1;
      end
      priority if (fill != '0) begin
        status_next = csem_pkg::ST_WOKE;
      end else if (count == csem_pkg::COUNT_MAX) begin
        status_next = csem_pkg::ST_SATURATED;
      end else begin
        status_next = csem_pkg::ST_RELEASED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && push) begin
      ring[tail] <= req_tid;
    end
    if (cmd.capture) begin
      rd_data  <= ring[head];
      req_kind <= kind;
      req_tid  <= thread_id[csem_pkg::ID_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else begin
      priority if (cfg_we) begin
        count <= cfg_wdata;
      end else if (cmd.execute) begin
        count <= count_next;
      end
      if (cmd.execute) begin
        head <= head_next;
        tail <= tail_next;
        fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status        <= status_next;
      woken_thread  <= csem_pkg::THREAD_W'(woken_next);
      count_after   <= count_next;
      waiters_after <= csem_pkg::WAITERS_W'(fill_next);
    end
  end

endmodule

// File: src/counting_semaphore_wait_queue_unit.sv
// Top level of the counting semaphore with FIFO wait queue.
// A request is captured in the idle state; its result is registered by the execute step.
// Requests are handled one at a time (capture/read of the ring head, then execute); no new one is taken meanwhile.
// The execute step waits while a previous result is still stalled at the output.
// Reset (rst, synchronous): count, ring pointers, fill and output valid clear;
// ring entries are not cleared; a read entry is only used when the queue holds a waiter.
module counting_semaphore_wait_queue_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [csem_pkg::COUNT_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [csem_pkg::THREAD_W-1:0]     thread_id,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [csem_pkg::STATUS_W-1:0]     status,
  output logic [csem_pkg::THREAD_W-1:0]     woken_thread,
  output logic [csem_pkg::COUNT_W-1:0]      count_after,
  output logic [csem_pkg::WAITERS_W-1:0]    waiters_after
);

  csem_pkg::csem_cmd_t cmd;

  csem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  csem_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .kind          (kind),
    .thread_id     (thread_id),
    .status        (status),
    .woken_thread  (woken_thread),
    .count_after   (count_after),
    .waiters_after (waiters_after)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous request in flight");

  a_queued_zero_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == csem_pkg::ST_QUEUED) |-> (count_after == '0))
    else $error("request queued with nonzero count");

  a_full_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == csem_pkg::ST_FULL) |->
      (count_after == '0 &&
       waiters_after == csem_pkg::WAITERS_W'(csem_pkg::QUEUE_DEPTH)))
    else $error("queue full reported with inconsistent state");

  a_saturated_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == csem_pkg::ST_SATURATED) |->
      (count_after == csem_pkg::COUNT_MAX && waiters_after == '0))
    else $error("saturation reported with inconsistent state");

endmodule
